FILE: rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle, outside reset
`define GBLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gble assertion failed");

// antecedent in this cycle implies consequent in the next cycle, outside reset
`define GBLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gble assertion failed");

// checked at every edge, reset included
`define GBLE_ASSERT_ALWAYS(label, clk, cond) \
    label: assert property (@(posedge clk) (cond)) \
        else $error("gble assertion failed");

`endif

FILE: rtl/gble_pkg.sv
// shared constants, types and command/status structs of the line editor
`default_nettype none

package gble_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [7:0] KEY_LEFT  = 8'h3C;
    localparam logic [7:0] KEY_RIGHT = 8'h3E;
    localparam logic [7:0] KEY_BACK  = 8'h2D;

    typedef enum logic [1:0] {
        KC_LEFT,
        KC_RIGHT,
        KC_BACK,
        KC_INSERT
    } key_class_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEFT_WR,
        ST_RIGHT_WR,
        ST_EMIT_OUT
    } gble_state_t;

    typedef struct packed {
        logic clear_pos;
        logic left_rd;
        logic left_wr;
        logic right_rd;
        logic right_wr;
        logic back_del;
        logic insert;
        logic set_ovf;
        logic emit_rd;
        logic emit_out;
    } gble_cmd_t;

    typedef struct packed {
        logic       op;
        key_class_t kclass;
        logic       front_zero;
        logic       back_zero;
        logic       full;
        logic       out_free;
    } gble_sts_t;

endpackage

`default_nettype wire

FILE: rtl/gble_chan_if.sv
// request and result channel interfaces of the line editor
`default_nettype none

interface gble_key_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink (input valid, input op, input key, output ready);
endinterface

interface gble_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       is_last;
    logic       line_empty;
    logic       overflowed;

    modport source (output valid, output out_char, output is_last, output line_empty,
                    output overflowed, input ready);
    modport sink (input valid, input out_char, input is_last, input line_empty,
                  input overflowed, output ready);
endinterface

`default_nettype wire

FILE: rtl/gble_ctrl.sv
// controller state machine: sequences memory accesses for each request
`default_nettype none

module gble_ctrl
    import gble_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire gble_sts_t sts,
    output gble_cmd_t      cmd
);

    gble_state_t state_reg;
    gble_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (sts.op)
                    begin
                        cmd.emit_rd = 1'b1;
                        state_next  = ST_EMIT_OUT;
                    end
                    else
                    begin
                        cmd.clear_pos = 1'b1;
                        case (sts.kclass)
                            KC_LEFT:
                            begin
                                if (!sts.front_zero)
                                begin
                                    cmd.left_rd = 1'b1;
                                    state_next  = ST_LEFT_WR;
                                end
                            end
                            KC_RIGHT:
                            begin
                                if (!sts.back_zero)
                                begin
                                    cmd.right_rd = 1'b1;
                                    state_next   = ST_RIGHT_WR;
                                end
                            end
                            KC_BACK:
                            begin
                                cmd.back_del = !sts.front_zero;
                            end
                            default:
                            begin
                                cmd.insert  = !sts.full;
                                cmd.set_ovf = sts.full;
                            end
                        endcase
                    end
                end
            end
            ST_LEFT_WR:
            begin
                cmd.left_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_RIGHT_WR:
            begin
                cmd.right_wr = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_EMIT_OUT:
            begin
                // wait for the result register to drain
                if (sts.out_free)
                begin
                    cmd.emit_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/gble_dp.sv
// datapath: buffer memory, stack counters, emit position and result register
`default_nettype none

module gble_dp
    import gble_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_op,
    input  wire logic [7:0] req_key,
    input  wire gble_cmd_t  cmd,
    output gble_sts_t       sts,
    input  wire logic       res_ready,
    output logic            res_valid,
    output logic [7:0]      res_char,
    output logic            res_last,
    output logic            res_empty,
    output logic            res_ovf
);

    logic [7:0] mem [CAPACITY];
    logic [7:0] rd_data_reg;

    logic [CNT_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] pos_plus_reg, pos_plus_next;
    logic             ovf_reg, ovf_next;
    logic             elast_reg, elast_next;
    logic             eempty_reg, eempty_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;
    logic             out_empty_reg, out_empty_next;
    logic             out_ovf_reg, out_ovf_next;

    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  pos_eff;
    logic [CNT_W-1:0]  pos_plus;
    logic [CNT_W-1:0]  emit_idx;
    logic [CNT_W-1:0]  back_top;
    logic [CNT_W-1:0]  addr_wide;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic              mem_re;
    logic [7:0]        mem_wdata;
    logic              out_free;

    assign total    = front_reg + back_reg;
    assign pos_eff  = (pos_reg >= total) ? '0 : pos_reg;
    assign pos_plus = pos_eff + CNT_W'(1);
    assign back_top = CAP_CNT - back_reg;
    // back stack is read top to bottom after the front stack
    assign emit_idx = (pos_eff < front_reg) ? pos_eff : back_top + (pos_eff - front_reg);
    assign out_free = !out_valid_reg || res_ready;

    always_comb
    begin
        sts.op         = req_op;
        sts.front_zero = (front_reg == '0);
        sts.back_zero  = (back_reg == '0);
        sts.full       = (total == CAP_CNT);
        sts.out_free   = out_free;
        case (req_key)
            KEY_LEFT:  sts.kclass = KC_LEFT;
            KEY_RIGHT: sts.kclass = KC_RIGHT;
            KEY_BACK:  sts.kclass = KC_BACK;
            default:   sts.kclass = KC_INSERT;
        endcase
    end

    // single memory port address select
    always_comb
    begin
        if (cmd.left_rd)
        begin
            addr_wide = front_reg - CNT_W'(1);
        end
        else if (cmd.left_wr || cmd.right_rd)
        begin
            addr_wide = back_top;
        end
        else if (cmd.emit_rd)
        begin
            addr_wide = emit_idx;
        end
        else
        begin
            addr_wide = front_reg;
        end
    end

    assign mem_addr  = addr_wide[ADDR_W-1:0];
    assign mem_we    = cmd.left_wr || cmd.right_wr || cmd.insert;
    assign mem_re    = cmd.left_rd || cmd.right_rd || cmd.emit_rd;
    assign mem_wdata = cmd.insert ? req_key : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        front_next     = front_reg;
        back_next      = back_reg;
        pos_next       = pos_reg;
        pos_plus_next  = pos_plus_reg;
        ovf_next       = ovf_reg || cmd.set_ovf;
        elast_next     = elast_reg;
        eempty_next    = eempty_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;

        if (cmd.clear_pos)
        begin
            pos_next = '0;
        end
        if (cmd.left_rd)
        begin
            front_next = front_reg - CNT_W'(1);
            back_next  = back_reg + CNT_W'(1);
        end
        if (cmd.right_rd)
        begin
            back_next = back_reg - CNT_W'(1);
        end
        if (cmd.right_wr || cmd.insert)
        begin
            front_next = front_reg + CNT_W'(1);
        end
        if (cmd.back_del)
        begin
            front_next = front_reg - CNT_W'(1);
        end
        if (cmd.emit_rd)
        begin
            eempty_next   = (total == '0);
            elast_next    = (pos_plus == total);
            pos_plus_next = pos_plus;
        end
        if (cmd.emit_out)
        begin
            out_valid_next = 1'b1;
            out_char_next  = eempty_reg ? 8'h00 : rd_data_reg;
            out_last_next  = eempty_reg || elast_reg;
            out_empty_next = eempty_reg;
            out_ovf_next   = ovf_reg;
            if (eempty_reg || elast_reg)
            begin
                pos_next   = '0;
                front_next = '0;
                back_next  = '0;
            end
            else
            begin
                pos_next = pos_plus_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            back_reg      <= '0;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            back_reg      <= back_next;
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_plus_reg  <= pos_plus_next;
        elast_reg     <= elast_next;
        eempty_reg    <= eempty_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign res_valid = out_valid_reg;
    assign res_char  = out_char_reg;
    assign res_last  = out_last_reg;
    assign res_empty = out_empty_reg;
    assign res_ovf   = out_ovf_reg;

endmodule

`default_nettype wire

FILE: rtl/gap_buffer_line_editor_core.sv
// Line editor with a gap buffer kept as two stacks in one single-port memory.
// key_chan carries requests: op 0 edits with key ('<' left, '>' right,
// '-' backspace, anything else inserted at the cursor), op 1 asks for the
// next character of the line. line_chan carries one result per emit request:
// out_char, is_last, line_empty and the sticky overflowed flag.
// Insert, backspace and ignored keys finish when taken. In a cursor move
// the memory port reads one stack top and then writes the other.
// An emit request reads the memory and then loads the result register,
// which drives line_chan.
// Requests are handled one at a time; the next request is taken once the
// current one is finished, so a move or emit holds off the next request.
// The result register parts the two sides: edit requests are still taken
// while a result waits; a following emit holds in its load step until
// line_chan is ready.
// Reset clears the stack counts, emit position and overflow flag at once;
// the buffer memory needs no clearing as only written entries ever reach the output.
`default_nettype none

module gap_buffer_line_editor_core
    import gble_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    gble_key_if.sink    key_chan,
    gble_line_if.source line_chan
);

    gble_cmd_t cmd;
    gble_sts_t sts;

    gble_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (key_chan.valid),
        .req_ready (key_chan.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gble_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_op    (key_chan.op),
        .req_key   (key_chan.key),
        .cmd       (cmd),
        .sts       (sts),
        .res_ready (line_chan.ready),
        .res_valid (line_chan.valid),
        .res_char  (line_chan.out_char),
        .res_last  (line_chan.is_last),
        .res_empty (line_chan.line_empty),
        .res_ovf   (line_chan.overflowed)
    );

endmodule

`default_nettype wire

FILE: rtl/gble_checker.sv
// port-level checker of the line editor and its bind to the top level
`default_nettype none
`include "assert_macros.svh"

module gble_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       key_valid,
    input wire logic       key_ready,
    input wire logic       key_op,
    input wire logic       line_valid,
    input wire logic       line_ready,
    input wire logic [7:0] out_char,
    input wire logic       is_last,
    input wire logic       line_empty,
    input wire logic       overflowed
);

    logic emit_taken;
    logic line_stall;

    assign emit_taken = key_valid && key_ready && key_op;
    assign line_stall = line_valid && !line_ready;

    // an empty line gives a single zero character that closes the line
    `GBLE_ASSERT_SAME(a_empty_result, clk, rst_n, line_valid && line_empty,
        is_last && (out_char == 8'h00))
    // an emit request keeps the block busy while it loads the result register
    `GBLE_ASSERT_NEXT(a_emit_busy, clk, rst_n, emit_taken, !key_ready)
    // a stalled result holds
    `GBLE_ASSERT_NEXT(a_result_hold, clk, rst_n, line_stall,
        line_valid && $stable(out_char) && $stable(is_last) &&
        $stable(line_empty) && $stable(overflowed))
    // no result is offered while reset is applied
    `GBLE_ASSERT_ALWAYS(a_reset_quiet, clk, rst_n || !line_valid)

endmodule

bind gap_buffer_line_editor_core gble_checker u_gble_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_valid  (key_chan.valid),
    .key_ready  (key_chan.ready),
    .key_op     (key_chan.op),
    .line_valid (line_chan.valid),
    .line_ready (line_chan.ready),
    .out_char   (line_chan.out_char),
    .is_last    (line_chan.is_last),
    .line_empty (line_chan.line_empty),
    .overflowed (line_chan.overflowed)
);

`default_nettype wire
